### src/assert_macros.svh
// Assertion macros for the checker file of the VLAN filter.
// No dependencies; included by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define PVMF_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("assertion failed");

// Same-cycle implication.
`define PVMF_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication.
`define PVMF_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### src/pvmf_pkg.sv
// Package of the port VLAN membership filter: sizes, codes and cell control.
// No dependencies; imported by every module of the block.
`default_nettype none

package pvmf_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int VID_W       = 12;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Item commands.
    typedef enum logic [1:0] {
        CMD_INGRESS = 2'd0,
        CMD_EGRESS  = 2'd1,
        CMD_ADD     = 2'd2,
        CMD_REMOVE  = 2'd3
    } cmd_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BRIDGE_ATTACHED = 2'd0;
    localparam logic [1:0] CFG_FILTERING_ON    = 2'd1;
    localparam logic [1:0] CFG_PROTO_8021AD    = 2'd2;

    // Commands broadcast along the row of cells.
    typedef struct packed {
        logic upd_match;   // matching cell takes the new untagged flag
        logic shift_hit;   // cells at or above the hit take their upper neighbor
    } cell_ctrl_t;

endpackage

`default_nettype wire

### src/pvmf_cell.sv
// One slot of the VLAN membership table: id, untagged flag and compare.
// Depends on pvmf_pkg.
`default_nettype none

module pvmf_cell
    import pvmf_pkg::*;
(
    input  wire logic             clk,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic             load,
    input  wire logic             occupied,
    input  wire logic [VID_W-1:0] key_vid,
    input  wire logic             key_untag,
    input  wire logic [VID_W-1:0] nbr_vid,
    input  wire logic             nbr_untag,
    input  wire logic             hit_below,
    output logic      [VID_W-1:0] vid,
    output logic                  untag,
    output logic                  match,
    output logic                  hit_upto
);

    logic [VID_W-1:0] vid_reg;
    logic             untag_reg;

    // Compare the key against this slot and extend the hit chain.
    assign match    = occupied && (vid_reg == key_vid);
    assign hit_upto = hit_below || match;
    assign vid      = vid_reg;
    assign untag    = untag_reg;

    // Slot contents: shift down on remove, load on insert, flag update on hit.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift_hit && hit_upto)
        begin
            vid_reg   <= nbr_vid;
            untag_reg <= nbr_untag;
        end
        else if (load)
        begin
            vid_reg   <= key_vid;
            untag_reg <= key_untag;
        end
        else if (ctrl.upd_match && match)
        begin
            untag_reg <= key_untag;
        end
    end

endmodule

`default_nettype wire

### src/port_vlan_membership_filter_top.sv
// Top level of the port VLAN membership filter: row of table cells,
// fill count, PVID, configuration registers and the result register.
// Depends on pvmf_pkg and pvmf_cell.
//
//  channel   handshake                  payload
//  item      item_valid / item_stall    command, vlan_id, tag and entry flags
//  result    result_valid/result_stall  result_vid, out tag fields, status
//  config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Every item is looked up in all 16 cells at once and its result is
// registered at the accepting edge: one item per cycle while item_stall is low.
// The row of cells and the fill count update at the same edge.
// Reset clears the fill count, the PVID and the configuration; table
// contents are meaningful only below the fill count.
// A waiting result stalls the item side only while result_stall is high.
`default_nettype none

module port_vlan_membership_filter_top
    import pvmf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire logic [1:0]       command,
    input  wire logic [VID_W-1:0] vlan_id,
    input  wire logic             tag_present,
    input  wire logic             tag_is_8021ad,
    input  wire logic             entry_untagged,
    input  wire logic             entry_is_pvid,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output logic      [VID_W-1:0] result_vid,
    output logic                  out_tag_present,
    output logic                  out_tag_is_8021ad,
    output logic      [1:0]       status,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic             cfg_data
);

    logic             bridge_reg;
    logic             filter_reg;
    logic             proto_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [VID_W-1:0] pvid_reg, pvid_next;
    logic             valid_reg;
    logic [VID_W-1:0] rvid_reg, rvid_next;
    logic             otag_reg, otag_next;
    logic             oad_reg, oad_next;
    status_t          status_reg, status_next;

    logic                   accept;
    cmd_t                   cmd;
    cell_ctrl_t             ctrl;
    logic [TABLE_DEPTH-1:0] load;
    logic [TABLE_DEPTH-1:0] occupied;
    logic [TABLE_DEPTH-1:0] match;
    logic [TABLE_DEPTH-1:0] untag;
    logic [TABLE_DEPTH:0]   hit;
    logic [VID_W-1:0]       cell_vid [TABLE_DEPTH];
    logic [VID_W-1:0]       nbr_vid  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] nbr_untag;
    logic                   found;
    logic                   hit_untag;
    logic                   add_new;

    assign cmd          = cmd_t'(command);
    assign accept       = item_valid && !item_stall;
    assign item_stall   = valid_reg && result_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = valid_reg;
    assign result_vid   = rvid_reg;
    assign out_tag_present   = otag_reg;
    assign out_tag_is_8021ad = oad_reg;
    assign status       = status_reg;

    // Row of cells; on a remove, cells at or above the hit take their upper neighbor's contents.
    assign hit[0] = 1'b0;
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        assign occupied[i] = (CNT_W'(i) < count_reg);
        assign load[i]     = add_new && (CNT_W'(i) == count_reg);
        if (i == TABLE_DEPTH - 1)
        begin : g_top
            assign nbr_vid[i]   = cell_vid[i];
            assign nbr_untag[i] = untag[i];
        end
        else
        begin : g_mid
            assign nbr_vid[i]   = cell_vid[i+1];
            assign nbr_untag[i] = untag[i+1];
        end
        pvmf_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .load      (load[i]),
            .occupied  (occupied[i]),
            .key_vid   (vlan_id),
            .key_untag (entry_untagged),
            .nbr_vid   (nbr_vid[i]),
            .nbr_untag (nbr_untag[i]),
            .hit_below (hit[i]),
            .vid       (cell_vid[i]),
            .untag     (untag[i]),
            .match     (match[i]),
            .hit_upto  (hit[i+1])
        );
    end

    assign found     = hit[TABLE_DEPTH];
    assign hit_untag = |(match & untag);

    // Command decode, table control and the next result.
    always_comb
    begin
        count_next  = count_reg;
        pvid_next   = pvid_reg;
        rvid_next   = '0;
        otag_next   = 1'b0;
        oad_next    = 1'b0;
        status_next = ST_OK;
        add_new     = 1'b0;
        ctrl        = '0;
        unique case (cmd)
            CMD_INGRESS:
            begin
                if (bridge_reg && filter_reg)
                begin
                    if (tag_present && (tag_is_8021ad == proto_reg) && found)
                        rvid_next = vlan_id;
                    else
                        rvid_next = pvid_reg;
                end
            end
            CMD_EGRESS:
            begin
                if (bridge_reg && found && !hit_untag)
                begin
                    rvid_next = vlan_id;
                    otag_next = 1'b1;
                    oad_next  = proto_reg;
                end
            end
            CMD_ADD:
            begin
                if (found)
                begin
                    ctrl.upd_match = accept;
                    if (entry_is_pvid)
                        pvid_next = vlan_id;
                end
                else if (count_reg == CNT_W'(TABLE_DEPTH))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    add_new    = accept;
                    count_next = count_reg + CNT_W'(1);
                    if (entry_is_pvid)
                        pvid_next = vlan_id;
                end
            end
            CMD_REMOVE:
            begin
                if (!found)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    ctrl.shift_hit = accept;
                    count_next     = count_reg - CNT_W'(1);
                    if (vlan_id == pvid_reg)
                        pvid_next = '0;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Control state: fill count, PVID and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pvid_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
                pvid_reg  <= pvid_next;
                valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result beat payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rvid_reg   <= rvid_next;
            otag_reg   <= otag_next;
            oad_reg    <= oad_next;
            status_reg <= status_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bridge_reg <= 1'b0;
            filter_reg <= 1'b0;
            proto_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BRIDGE_ATTACHED: bridge_reg <= cfg_data;
                CFG_FILTERING_ON:    filter_reg <= cfg_data;
                CFG_PROTO_8021AD:    proto_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

endmodule

`default_nettype wire

### src/pvmf_checker.sv
// Port-level checker for the VLAN filter top level, bound to it below.
// Depends on pvmf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pvmf_checker
    import pvmf_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_valid,
    input wire logic             item_stall,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire logic [VID_W-1:0] result_vid,
    input wire logic             out_tag_present,
    input wire logic             out_tag_is_8021ad,
    input wire logic [1:0]       status
);

    // A stalled result beat holds.
    `PVMF_ASSERT_NEXT(a_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result_vid) && $stable(status))
    // Every accepted item yields a result beat in the next cycle.
    `PVMF_ASSERT_NEXT(a_latency, clk, rst_n, item_valid && !item_stall, result_valid)
    // Error results carry no VLAN and no tag.
    `PVMF_ASSERT_IMP(a_err_clean, clk, rst_n, result_valid && (status != ST_OK), (result_vid == '0) && !out_tag_present)
    // The 802.1ad tag type is given only with a tag.
    `PVMF_ASSERT_IMP(a_ad_tag, clk, rst_n, result_valid && out_tag_is_8021ad, out_tag_present)
    // No unused status code appears.
    `PVMF_ASSERT(a_status, clk, rst_n, !result_valid || (status != 2'd3))

endmodule

bind port_vlan_membership_filter_top pvmf_checker u_pvmf_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .result_vid        (result_vid),
    .out_tag_present   (out_tag_present),
    .out_tag_is_8021ad (out_tag_is_8021ad),
    .status            (status)
);

`default_nettype wire
